// ----- rtl/core/crc8_frame_deframer_core_assert.svh -----
// Assertion macros shared by the deframer RTL.
// Expects clk and rst_n in scope where used.
`ifndef CRC8_FRAME_DEFRAMER_CORE_ASSERT_SVH
`define CRC8_FRAME_DEFRAMER_CORE_ASSERT_SVH

// expr must hold at every clock edge out of reset
`define CDF_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// ante implies cons in the same cycle
`define CDF_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ----- rtl/core/cdf_pkg.sv -----
// Shared types, constants and the CRC-8 byte step for the frame deframer.
// No dependencies.
package cdf_pkg;

  localparam int MAX_RESULTS = 64;
  localparam int HDR_BYTES   = 4;   // preamble, length, sequence, id
  localparam int CRC_EXTRA   = 2;   // sequence and id covered beyond the length byte

  typedef enum logic [1:0] {
    REG_PREAMBLE = 2'd0,
    REG_POLY     = 2'd1,
    REG_INIT     = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    CMD_PUSH  = 1'b0,
    CMD_CLEAR = 1'b1
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] data;
  } cmd_t;

  typedef struct packed {
    logic [7:0] preamble;
    logic [7:0] poly;
    logic [7:0] init;
  } cfg_t;

  typedef struct packed {
    logic [7:0] seq_number;
    logic [7:0] frame_id;
    logic [5:0] payload_count;
    logic       has_payload;
    logic [7:0] payload_byte;
    logic [4:0] byte_index;
    logic       frame_end;
    logic       run_last;
  } res_t;

  // MSB-first CRC-8 over one byte
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in,
                                           input logic [7:0] data,
                                           input logic [7:0] poly);
    logic [7:0] c;
    c = crc_in ^ data;
    for (int b = 0; b < 8; b++) begin
      if (c[7]) c = {c[6:0], 1'b0} ^ poly;
      else      c = {c[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage

// ----- rtl/core/cdf_if.sv -----
// Valid/ready channel interfaces for the deframer input and result streams.
// No dependencies.
interface cdf_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] rx_byte;
  modport source (output valid, func, rx_byte, input ready);
  modport sink   (input valid, func, rx_byte, output ready);
endinterface

interface cdf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] seq_number;
  logic [7:0] frame_id;
  logic [5:0] payload_count;
  logic       has_payload;
  logic [7:0] payload_byte;
  logic [4:0] byte_index;
  logic       frame_end;
  logic       run_last;
  modport source (output valid, seq_number, frame_id, payload_count, has_payload,
                  payload_byte, byte_index, frame_end, run_last, input ready);
  modport sink   (input valid, seq_number, frame_id, payload_count, has_payload,
                  payload_byte, byte_index, frame_end, run_last, output ready);
endinterface

// ----- rtl/core/cdf_front.sv -----
// Input side: takes transfers, classifies them and queues them (2 entries).
// Depends on cdf_pkg and cdf_in_if.
module cdf_front import cdf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  cdf_in_if.sink     in_if,
  output logic       cmd_valid,
  output cmd_t       cmd,
  input  logic       cmd_ready
);

  cmd_t       q_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;
  cmd_t       in_cmd;

  assign in_if.ready = (cnt_r != 2'd2);
  assign push        = in_if.valid && in_if.ready;
  assign cmd_valid   = (cnt_r != 2'd0);
  assign pop         = cmd_valid && cmd_ready;
  assign cmd         = q_r[rp_r];

  always_comb begin
    in_cmd.kind = in_if.func ? CMD_CLEAR : CMD_PUSH;
    in_cmd.data = in_if.rx_byte;
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= in_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ----- rtl/core/cdf_back.sv -----
// Back end: byte ring, frame scan with CRC check, result emission and output register.
// Depends on cdf_pkg, cdf_out_if and the assertion macro header.
`include "crc8_frame_deframer_core_assert.svh"
module cdf_back import cdf_pkg::*; #(
  parameter int RING_DEPTH  = 64,
  parameter int MAX_PAYLOAD = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cmd_valid,
  input  cmd_t       cmd,
  output logic       cmd_ready,
  input  cfg_t       cfg,
  cdf_out_if.source  out_if
);

  localparam int PW = $clog2(RING_DEPTH);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_CHK  = 9'b000000010,
    S_PRE  = 9'b000000100,
    S_LEN  = 9'b000001000,
    S_CRC  = 9'b000010000,
    S_SEQ  = 9'b000100000,
    S_ID   = 9'b001000000,
    S_EMIT = 9'b010000000,
    S_FIN  = 9'b100000000
  } state_t;

  state_t        state_r, state_nxt;
  logic [PW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [PW-1:0] off_r, off_nxt;
  logic [7:0]    len_r, len_nxt, crc_r, crc_nxt;
  logic [7:0]    seq_r, seq_nxt, id_r, id_nxt, k_r, k_nxt;
  logic [6:0]    n_r, n_nxt;
  logic          pend_v_r, pend_v_nxt;
  res_t          pend_r, pend_nxt;
  logic          out_v_r, out_v_nxt;
  res_t          out_r, out_nxt;

  logic [7:0]    ring_mem [RING_DEPTH];
  logic [7:0]    rd_data_r;
  logic [PW-1:0] rd_off, rd_addr, wp_inc;
  logic          mem_we;
  logic [PW-1:0] fill;
  logic [8:0]    total, plen, need;
  logic          slot_free;
  res_t          new_res;

  function automatic logic [PW-1:0] ring_add(input logic [PW-1:0] a, input logic [PW-1:0] b);
    logic [PW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (PW+1)'(RING_DEPTH)) s = s - (PW+1)'(RING_DEPTH);
    return s[PW-1:0];
  endfunction

  always_comb begin
    if (wp_r >= rp_r) fill = wp_r - rp_r;
    else              fill = PW'(RING_DEPTH) - (rp_r - wp_r);
  end

  assign wp_inc    = ring_add(wp_r, PW'(1));
  assign total     = {1'b0, len_r} + 9'(HDR_BYTES);
  assign plen      = {1'b0, len_r} - 9'd1;
  assign need      = (plen == 9'd0) ? 9'd1 : plen;
  assign slot_free = !out_v_r || out_if.ready;
  assign cmd_ready = (state_r == S_IDLE);
  assign rd_addr   = ring_add(rp_r, rd_off);

  always_comb begin
    new_res.seq_number    = seq_r;
    new_res.frame_id      = id_r;
    new_res.payload_count = plen[5:0];
    new_res.has_payload   = (plen != 9'd0);
    new_res.payload_byte  = (plen != 9'd0) ? rd_data_r : 8'd0;
    new_res.byte_index    = (plen != 9'd0) ? k_r[4:0] : 5'd0;
    new_res.frame_end     = ({1'b0, k_r} + 9'd1 == need);
    new_res.run_last      = 1'b0;
  end

  always_comb begin
    state_nxt  = state_r;
    wp_nxt     = wp_r;
    rp_nxt     = rp_r;
    off_nxt    = off_r;
    len_nxt    = len_r;
    crc_nxt    = crc_r;
    seq_nxt    = seq_r;
    id_nxt     = id_r;
    k_nxt      = k_r;
    n_nxt      = n_r;
    pend_v_nxt = pend_v_r;
    pend_nxt   = pend_r;
    out_v_nxt  = out_v_r && !out_if.ready;
    out_nxt    = out_r;
    rd_off     = '0;
    mem_we     = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          if (cmd.kind == CMD_CLEAR) begin
            rp_nxt = wp_r;
          end else if (wp_inc == rp_r) begin
            rp_nxt = wp_r;  // full: byte dropped, ring emptied
          end else begin
            mem_we    = 1'b1;
            wp_nxt    = wp_inc;
            n_nxt     = '0;
            state_nxt = S_CHK;
          end
        end
      end
      S_CHK: begin
        rd_off    = '0;
        state_nxt = (fill == '0) ? S_FIN : S_PRE;
      end
      S_PRE: begin
        rd_off = PW'(1);
        if (rd_data_r != cfg.preamble) begin
          rp_nxt    = ring_add(rp_r, PW'(1));
          state_nxt = S_CHK;
        end else if (fill < PW'(2)) begin
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_LEN;
        end
      end
      S_LEN: begin
        len_nxt = rd_data_r;
        if (rd_data_r == 8'd0 || {1'b0, rd_data_r} > 9'(MAX_PAYLOAD + 1)) begin
          rp_nxt    = ring_add(rp_r, PW'(1));
          state_nxt = S_CHK;
        end else if (16'(fill) < 16'({1'b0, rd_data_r} + 9'(HDR_BYTES))) begin
          state_nxt = S_FIN;
        end else begin
          crc_nxt   = crc8_byte(cfg.init, rd_data_r, cfg.poly);
          off_nxt   = PW'(2);
          rd_off    = PW'(2);
          state_nxt = S_CRC;
        end
      end
      S_CRC: begin
        if (16'(off_r) == 16'(total) - 16'd1) begin
          if (crc_r != rd_data_r) begin
            rp_nxt    = ring_add(rp_r, PW'(1));
            state_nxt = S_CHK;
          end else if (16'(n_r) + 16'(need) > 16'(MAX_RESULTS)) begin
            state_nxt = S_FIN;  // frame stays for a later push
          end else begin
            rd_off    = PW'(CRC_EXTRA);
            state_nxt = S_SEQ;
          end
        end else begin
          crc_nxt = crc8_byte(crc_r, rd_data_r, cfg.poly);
          off_nxt = off_r + PW'(1);
          rd_off  = off_r + PW'(1);
        end
      end
      S_SEQ: begin
        seq_nxt   = rd_data_r;
        rd_off    = PW'(CRC_EXTRA + 1);
        state_nxt = S_ID;
      end
      S_ID: begin
        id_nxt    = rd_data_r;
        k_nxt     = '0;
        rd_off    = PW'(HDR_BYTES);
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        rd_off = PW'(HDR_BYTES) + PW'(k_r);
        if (!pend_v_r || slot_free) begin
          if (pend_v_r) begin
            out_v_nxt = 1'b1;
            out_nxt   = pend_r;
          end
          pend_v_nxt = 1'b1;
          pend_nxt   = new_res;
          if (new_res.frame_end) begin
            rp_nxt    = ring_add(rp_r, PW'(total));
            n_nxt     = n_r + 7'(need);
            state_nxt = S_CHK;
          end else begin
            k_nxt  = k_r + 8'd1;
            rd_off = PW'(HDR_BYTES) + PW'(k_r) + PW'(1);
          end
        end
      end
      S_FIN: begin
        if (!pend_v_r) begin
          state_nxt = S_IDLE;
        end else if (slot_free) begin
          out_v_nxt         = 1'b1;
          out_nxt           = pend_r;
          out_nxt.run_last  = 1'b1;
          pend_v_nxt        = 1'b0;
          state_nxt         = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) ring_mem[wp_r] <= cmd.data;
    rd_data_r <= ring_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    off_r  <= off_nxt;
    len_r  <= len_nxt;
    crc_r  <= crc_nxt;
    seq_r  <= seq_nxt;
    id_r   <= id_nxt;
    k_r    <= k_nxt;
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      wp_r     <= '0;
      rp_r     <= '0;
      n_r      <= '0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      wp_r     <= wp_nxt;
      rp_r     <= rp_nxt;
      n_r      <= n_nxt;
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  assign out_if.valid         = out_v_r;
  assign out_if.seq_number    = out_r.seq_number;
  assign out_if.frame_id      = out_r.frame_id;
  assign out_if.payload_count = out_r.payload_count;
  assign out_if.has_payload   = out_r.has_payload;
  assign out_if.payload_byte  = out_r.payload_byte;
  assign out_if.byte_index    = out_r.byte_index;
  assign out_if.frame_end     = out_r.frame_end;
  assign out_if.run_last      = out_r.run_last;

  `CDF_ASSERT_ALWAYS(a_ptr_range, (32'(rp_r) < RING_DEPTH) && (32'(wp_r) < RING_DEPTH), "ring pointer out of range")
  `CDF_ASSERT_IMPLY(a_idle_flushed, state_r == S_IDLE, !pend_v_r, "held result left at idle")
  `CDF_ASSERT_ALWAYS(a_result_cap, 32'(n_r) <= MAX_RESULTS, "result count over limit")

endmodule

// ----- rtl/core/crc8_frame_deframer_core.sv -----
// Top level of the CRC-8 frame deframer: config registers, front queue, back end.
// Depends on cdf_pkg, cdf_if, cdf_front and cdf_back.
//
//   port   dir      role
//   in_if  sink     func + rx_byte transfers
//   out_if source   one result per payload byte (or one per empty frame)
//   cfg_*  input    register writes: 0 preamble, 1 polynomial, 2 CRC init
//
// A push steps through the ring: a dropped byte, a frame header and its CRC (one byte
// per cycle), then the sequence, id and one result per payload byte for a good frame.
// Each CRC failure drops one byte and rescans. The ring is a one-write, one-read memory.
// Reset is synchronous; the ring contents need none. Output stalls hold the scan.
module crc8_frame_deframer_core import cdf_pkg::*; #(
  parameter int RING_DEPTH  = 64,
  parameter int MAX_PAYLOAD = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  cdf_in_if.sink     in_if,
  cdf_out_if.source  out_if,
  input  logic       cfg_we,
  input  logic [1:0] cfg_idx,
  input  logic [7:0] cfg_wdata
);

  cfg_t cfg_r, cfg_nxt;
  logic cmd_valid, cmd_ready;
  cmd_t cmd;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx)
        REG_PREAMBLE: cfg_nxt.preamble = cfg_wdata;
        REG_POLY:     cfg_nxt.poly     = cfg_wdata;
        REG_INIT:     cfg_nxt.init     = cfg_wdata;
        default:      cfg_nxt          = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{preamble: 8'hAA, poly: 8'h07, init: 8'h00};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  cdf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_ready (cmd_ready)
  );

  cdf_back #(
    .RING_DEPTH  (RING_DEPTH),
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_ready (cmd_ready),
    .cfg       (cfg_r),
    .out_if    (out_if)
  );

endmodule
